// ===== hdl/bxt_pkg.sv =====
// Shared codes, widths and the per-level step flags of the xor trie.
package bxt_pkg;

  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  localparam logic [1:0] MODE_INS = 2'd0;
  localparam logic [1:0] MODE_DEL = 2'd1;
  localparam logic [1:0] MODE_QRY = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  typedef logic [2:0] op_t;

  localparam op_t OP_ICHK = 3'd0;
  localparam op_t OP_IWR  = 3'd1;
  localparam op_t OP_DCHK = 3'd2;
  localparam op_t OP_DWR  = 3'd3;
  localparam op_t OP_QRY  = 3'd4;

  typedef struct packed {
    logic opp;
    logic miss;
    logic alloc;
    logic wr;
  } step_t;

endpackage

// ===== hdl/binary_xor_trie_core.sv =====
// Binary trie over keys with insert, delete and maximum xor query, one level per cycle.
//
//  channel | dir | beat contents                                   | handshake
//  in_     | in  | tuser[1:0] mode; tdata[29:0] key                | tvalid/tready
//  out_    | out | tdata[29:0] best_xor; tuser[0] found, [2:1] status| tvalid/tready
//
// One trie level per cycle through the node row memory (registered read).
// Query walks one pass; delete runs a check pass, then a count pass.
// Insert runs one write pass, after a check pass when fewer than KEY_BITS free nodes remain.
// Empty-trie queries, absent deletes, full pools and unused modes end early.
// in_tready is high only while idle; a waiting result sits in the output register.
// Synchronous active-low reset; no clearing pass (root and new rows read as empty).
module binary_xor_trie_core #(
  parameter int KEY_BITS  = 30,
  parameter int NODE_POOL = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [29:0] key
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [29:0] best_xor
  output logic [2:0]  out_tuser   // [0] found, [2:1] status
);
  import bxt_pkg::*;

  localparam int NW = $clog2(NODE_POOL);
  localparam int LW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int CW = NW + 8;
  localparam logic [CW-1:0] POOL_C = CW'(NODE_POOL);
  localparam logic [CW-1:0] KB_C   = CW'(KEY_BITS);
  localparam logic [LW-1:0] TOP_LVL = LW'(KEY_BITS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ICHK = 3'd1;
  localparam logic [2:0] S_IWR  = 3'd2;
  localparam logic [2:0] S_DCHK = 3'd3;
  localparam logic [2:0] S_DWR  = 3'd4;
  localparam logic [2:0] S_QRY  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [NW:0]         next_free_r, next_free_nxt;
  logic [CNT_W-1:0]    root_cnt_r, root_cnt_nxt;
  logic                root_ok_r;
  logic                out_valid_r;

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [NW-1:0]       node_r, node_nxt;
  logic [LW-1:0]       lvl_r, lvl_nxt;
  logic                fresh_r, fresh_nxt;
  logic [KEY_BITS-1:0] xor_r, xor_nxt;
  logic [29:0]         res_best_r, res_best_nxt;
  logic                res_found_r, res_found_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  logic [29:0]         out_best_r;
  logic                out_found_r;
  logic [1:0]          out_status_r;

  logic [1:0][CNT_W+NW-1:0] mem [NODE_POOL];
  logic [1:0][CNT_W+NW-1:0] rdata_r;
  logic [1:0][CNT_W+NW-1:0] row_eff;
  logic [1:0][CNT_W+NW-1:0] wr_row;
  logic [NW-1:0]            rd_addr;
  logic                     wr_en;

  logic [1:0][NW-1:0]    link_i, link_o;
  logic [1:0][CNT_W-1:0] cnt_i, cnt_o;
  logic [NW-1:0]         step_node;
  step_t                 flags;
  op_t                   op;

  logic [63:0]         key_wide;
  logic [KEY_BITS-1:0] key_in;
  logic [KEY_BITS-1:0] xor_upd;
  logic [63:0]         xor_wide;
  logic                last;
  logic                room_ok;
  logic                need_fail;
  logic                fin_load;

  assign key_wide = {34'b0, in_tdata[29:0]};
  assign key_in   = key_wide[KEY_BITS-1:0];

  assign row_eff = (fresh_r || (node_r == '0 && !root_ok_r)) ? '0 : rdata_r;

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      link_i[b] = row_eff[b][NW-1:0];
      cnt_i[b]  = row_eff[b][NW +: CNT_W];
      wr_row[b] = {cnt_o[b], link_o[b]};
    end
  end

  always_comb begin
    unique case (state_r)
      S_ICHK:  op = OP_ICHK;
      S_IWR:   op = OP_IWR;
      S_DCHK:  op = OP_DCHK;
      S_DWR:   op = OP_DWR;
      default: op = OP_QRY;
    endcase
  end

  bxt_level #(
    .NW(NW)
  ) u_level (
    .op        (op),
    .kbit      (key_r[lvl_r]),
    .link_i    (link_i),
    .cnt_i     (cnt_i),
    .free_node (next_free_r[NW-1:0]),
    .link_o    (link_o),
    .cnt_o     (cnt_o),
    .next_node (step_node),
    .flags     (flags)
  );

  assign last      = (lvl_r == '0);
  assign room_ok   = (POOL_C - CW'(next_free_r)) >= KB_C;
  assign need_fail = (CW'(next_free_r) + CW'(lvl_r) + CW'(1)) > POOL_C;
  assign xor_upd   = xor_r | (KEY_BITS'(flags.opp) << lvl_r);
  assign xor_wide  = 64'(xor_upd);
  assign wr_en     = flags.wr && (state_r == S_IWR || state_r == S_DWR);
  assign fin_load  = (state_r == S_FIN) && (!out_valid_r || out_tready);
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    next_free_nxt  = next_free_r;
    root_cnt_nxt   = root_cnt_r;
    key_nxt        = key_r;
    node_nxt       = step_node;
    lvl_nxt        = lvl_r - 1'b1;
    fresh_nxt      = 1'b0;
    xor_nxt        = xor_r;
    res_best_nxt   = res_best_r;
    res_found_nxt  = res_found_r;
    res_status_nxt = res_status_r;
    rd_addr        = step_node;
    unique case (state_r)
      S_IDLE: begin
        node_nxt = '0;
        lvl_nxt  = TOP_LVL;
        xor_nxt  = '0;
        rd_addr  = '0;
        if (in_tvalid) begin
          key_nxt        = key_in;
          res_best_nxt   = '0;
          res_found_nxt  = 1'b0;
          res_status_nxt = ST_OK;
          state_nxt      = S_FIN;
          unique case (in_tuser)
            MODE_INS: begin
              if (root_cnt_r == CNT_MAX) begin
                res_status_nxt = ST_FULL;
              end else if (room_ok) begin
                root_cnt_nxt = root_cnt_r + 1'b1;
                state_nxt    = S_IWR;
              end else begin
                state_nxt = S_ICHK;
              end
            end
            MODE_DEL: begin
              if (root_cnt_r == '0) begin
                res_status_nxt = ST_ABSENT;
              end else begin
                state_nxt = S_DCHK;
              end
            end
            MODE_QRY: begin
              if (root_cnt_r != '0) begin
                state_nxt = S_QRY;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ICHK: begin
        if (flags.miss && need_fail) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_FIN;
        end else if (flags.miss || last) begin
          root_cnt_nxt = root_cnt_r + 1'b1;
          node_nxt     = '0;
          lvl_nxt      = TOP_LVL;
          rd_addr      = '0;
          state_nxt    = S_IWR;
        end
      end
      S_IWR: begin
        fresh_nxt = flags.alloc;
        if (flags.alloc) begin
          next_free_nxt = next_free_r + 1'b1;
        end
        if (last) begin
          state_nxt = S_FIN;
        end
      end
      S_DCHK: begin
        if (flags.miss) begin
          res_status_nxt = ST_ABSENT;
          state_nxt      = S_FIN;
        end else if (last) begin
          root_cnt_nxt = root_cnt_r - 1'b1;
          node_nxt     = '0;
          lvl_nxt      = TOP_LVL;
          rd_addr      = '0;
          state_nxt    = S_DWR;
        end
      end
      S_DWR: begin
        if (last) begin
          state_nxt = S_FIN;
        end
      end
      S_QRY: begin
        xor_nxt = xor_upd;
        if (flags.miss) begin
          state_nxt = S_FIN;
        end else if (last) begin
          res_found_nxt = 1'b1;
          res_best_nxt  = xor_wide[29:0];
          state_nxt     = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_free_r <= (NW + 1)'(1);
      root_cnt_r  <= '0;
      root_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_free_r <= next_free_nxt;
      root_cnt_r  <= root_cnt_nxt;
      if (wr_en && node_r == '0) begin
        root_ok_r <= 1'b1;
      end
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    node_r       <= node_nxt;
    lvl_r        <= lvl_nxt;
    fresh_r      <= fresh_nxt;
    xor_r        <= xor_nxt;
    res_best_r   <= res_best_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
    if (fin_load) begin
      out_best_r   <= res_best_r;
      out_found_r  <= res_found_r;
      out_status_r <= res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[node_r] <= wr_row;
    end
    rdata_r <= mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_best_r};
  assign out_tuser  = {out_status_r, out_found_r};

endmodule

// ===== hdl/bxt_level.sv =====
// One trie level: decides the child, updates the node row, flags stop or allocation.
module bxt_level #(
  parameter int NW = 12
) (
  input  bxt_pkg::op_t                      op,
  input  logic                              kbit,
  input  logic [1:0][NW-1:0]                link_i,
  input  logic [1:0][bxt_pkg::CNT_W-1:0]    cnt_i,
  input  logic [NW-1:0]                     free_node,
  output logic [1:0][NW-1:0]                link_o,
  output logic [1:0][bxt_pkg::CNT_W-1:0]    cnt_o,
  output logic [NW-1:0]                     next_node,
  output bxt_pkg::step_t                    flags
);
  import bxt_pkg::*;

  logic [NW-1:0]    same_l;
  logic [NW-1:0]    opp_l;
  logic [CNT_W-1:0] same_c;
  logic [CNT_W-1:0] opp_c;
  logic             same_live;
  logic             opp_live;

  assign same_l    = link_i[kbit];
  assign opp_l     = link_i[~kbit];
  assign same_c    = cnt_i[kbit];
  assign opp_c     = cnt_i[~kbit];
  assign same_live = (same_l != '0) && (same_c != '0);
  assign opp_live  = (opp_l != '0) && (opp_c != '0);

  always_comb begin
    link_o    = link_i;
    cnt_o     = cnt_i;
    next_node = same_l;
    flags     = '0;
    unique case (op)
      OP_ICHK: begin
        flags.miss = (same_l == '0);
      end
      OP_IWR: begin
        flags.wr = 1'b1;
        if (same_l == '0) begin
          flags.alloc  = 1'b1;
          link_o[kbit] = free_node;
          cnt_o[kbit]  = CNT_W'(1);
          next_node    = free_node;
        end else begin
          cnt_o[kbit] = same_c + 1'b1;
        end
      end
      OP_DCHK: begin
        flags.miss = !same_live;
      end
      OP_DWR: begin
        flags.wr    = 1'b1;
        cnt_o[kbit] = same_c - 1'b1;
      end
      OP_QRY: begin
        if (opp_live) begin
          flags.opp = 1'b1;
          next_node = opp_l;
        end else if (!same_live) begin
          flags.miss = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/bxt_checker.sv =====
// Port-level checks of the xor trie core, bound to the top level.
module bxt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser
);
  import bxt_pkg::*;

  logic in_beat;

  assign in_beat = in_tvalid && in_tready && (in_tdata[31:30] == in_tdata[31:30])
                   && (in_tuser == in_tuser);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !in_tready)
    else $error("input taken while an item is in work");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[2:1] == ST_OK)
    else $error("found result with error status");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("nonzero xor without a found key");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[2:1] == ST_OK || out_tuser[2:1] == ST_FULL
                   || out_tuser[2:1] == ST_ABSENT)
    else $error("undefined status code");

endmodule

bind binary_xor_trie_core bxt_checker u_bxt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/binary_xor_trie_core_tb.sv =====
// Self-checking testbench for binary_xor_trie_core: trie predictor, stream drivers and checks.
module binary_xor_trie_core_tb;
  import bxt_pkg::*;

  localparam int KEY_BITS    = 30;
  localparam int NODE_POOL   = 4096;
  localparam int KEYSET      = 48;
  localparam int PHASE_ITEMS = 85;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 3000;
  localparam int TAIL_CYCLES = 80;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [29:0] best_xor;
    logic        found;
    logic [1:0]  status;
  } trie_result_t;

  class trie_tracker;
    bit [11:0]    links [2*NODE_POOL];
    bit [15:0]    counts [NODE_POOL];
    int unsigned  next_node;
    bit [15:0]    keys_held;
    trie_result_t pending_results [$];
    int           errors;
    int           full_seen;

    function new();
      next_node = 1;
      keys_held = '0;
      errors    = 0;
      full_seen = 0;
    endfunction

    function bit is_live(int unsigned c);
      return c != 0 && counts[c] != 0;
    endfunction

    function logic [1:0] insert_key(logic [29:0] key);
      int unsigned node, need, c;
      node = 0;
      need = 0;
      for (int i = KEY_BITS - 1; i >= 0; i--) begin
        c = links[2*node + key[i]];
        if (c == 0) begin
          need = i + 1;
          break;
        end
        node = c;
      end
      if (keys_held == CNT_MAX || next_node + need > NODE_POOL) return ST_FULL;
      keys_held++;
      counts[0] = keys_held;
      node = 0;
      for (int i = KEY_BITS - 1; i >= 0; i--) begin
        c = links[2*node + key[i]];
        if (c == 0) begin
          c = next_node;
          next_node++;
          counts[c] = '0;
          links[2*c] = '0;
          links[2*c + 1] = '0;
          links[2*node + key[i]] = c[11:0];
        end
        counts[c]++;
        node = c;
      end
      return ST_OK;
    endfunction

    function logic [1:0] delete_key(logic [29:0] key);
      int unsigned node, c;
      if (keys_held == 0) return ST_ABSENT;
      node = 0;
      for (int i = KEY_BITS - 1; i >= 0; i--) begin
        c = links[2*node + key[i]];
        if (!is_live(c)) return ST_ABSENT;
        node = c;
      end
      keys_held--;
      counts[0] = keys_held;
      node = 0;
      for (int i = KEY_BITS - 1; i >= 0; i--) begin
        c = links[2*node + key[i]];
        counts[c]--;
        node = c;
      end
      return ST_OK;
    endfunction

    function logic query_key(logic [29:0] key, output logic [29:0] best);
      int unsigned node, o, s;
      best = '0;
      if (keys_held == 0) return 1'b0;
      node = 0;
      for (int i = KEY_BITS - 1; i >= 0; i--) begin
        o = links[2*node + !key[i]];
        s = links[2*node + key[i]];
        if (is_live(o)) begin
          best[i] = 1'b1;
          node = o;
        end else if (is_live(s)) begin
          node = s;
        end else begin
          best = '0;
          return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function void note_op(logic [1:0] mode, logic [29:0] key);
      trie_result_t r;
      logic [29:0]  best;
      r = '0;
      case (mode)
        MODE_INS: r.status = insert_key(key);
        MODE_DEL: r.status = delete_key(key);
        MODE_QRY: begin
          r.found = query_key(key, best);
          r.best_xor = best;
        end
        default: ;
      endcase
      if (r.status == ST_FULL) full_seen++;
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void check_beat(logic [31:0] tdata, logic [2:0] tuser);
      trie_result_t want, got;
      got.best_xor = tdata[29:0];
      got.found    = tuser[0];
      got.status   = tuser[2:1];
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: best_xor=%h found=%0d status=%0d",
                   got.best_xor, got.found, got.status);
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: want xor=%h found=%0d status=%0d, got xor=%h found=%0d status=%0d",
                   want.best_xor, want.found, want.status,
                   got.best_xor, got.found, got.status);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [29:0] key
  logic [1:0]  in_tuser = '0;   // [1:0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [29:0] best_xor
  logic [2:0]  out_tuser;       // [0] found, [2:1] status

  trie_tracker sb = new();
  logic [29:0] keyset [KEYSET];
  int          send_idle = 0;
  int          recv_idle = 0;
  bit          hold_off = 1'b0;
  int          idle_cycles = 0;

  binary_xor_trie_core #(
    .KEY_BITS  (KEY_BITS),
    .NODE_POOL (NODE_POOL)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_op(in_tuser, in_tdata[29:0]);
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata, out_tuser);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("binary_xor_trie_core_tb: done, errors");
      $finish;
    end
  end

  // receiver; a long hold-off lets the block back up into its input
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_item(logic [1:0] mode, logic [29:0] key);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {2'b00, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_item();
    int unsigned r;
    logic [29:0] key;
    r   = $urandom_range(99);
    key = 30'($urandom());
    if (r < 35)      send_item(MODE_INS, keyset[$urandom_range(KEYSET - 1)]);
    else if (r < 55) send_item(MODE_DEL, keyset[$urandom_range(KEYSET - 1)]);
    else if (r < 85) send_item(MODE_QRY, key);
    else if (r < 92) send_item(MODE_INS, key);
    else if (r < 97) send_item(MODE_DEL, key);
    else             send_item(MODE_UNUSED, key);
  endtask

  initial begin
    int n;
    for (int k = 0; k < KEYSET; k++) keyset[k] = 30'($urandom());
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle = 14;
    recv_idle = 64;

    // directed: empty trie, extremes, duplicates, absent deletes, dead paths
    send_item(MODE_QRY, 30'h0000_0000);
    send_item(MODE_DEL, 30'h0000_0000);
    send_item(MODE_UNUSED, 30'h3FFF_FFFF);
    send_item(MODE_INS, 30'h0000_0000);
    send_item(MODE_INS, 30'h3FFF_FFFF);
    send_item(MODE_QRY, 30'h0000_0000);
    send_item(MODE_QRY, 30'h3FFF_FFFF);
    send_item(MODE_QRY, 30'h1555_5555);
    send_item(MODE_INS, 30'h0000_0000);
    send_item(MODE_DEL, 30'h0000_0000);
    send_item(MODE_QRY, 30'h3FFF_FFFF);
    send_item(MODE_DEL, 30'h0000_0000);
    send_item(MODE_DEL, 30'h0000_0000);
    send_item(MODE_QRY, 30'h3FFF_FFFF);
    send_item(MODE_DEL, 30'h2AAA_AAAA);
    send_item(MODE_INS, 30'h2AAA_AAAA);
    send_item(MODE_QRY, 30'h1555_5555);
    send_item(MODE_DEL, 30'h3FFF_FFFF);
    send_item(MODE_DEL, 30'h2AAA_AAAA);
    send_item(MODE_QRY, 30'h1234_5678);
    send_item(MODE_INS, 30'h1234_5678);
    send_item(MODE_QRY, 30'h0000_0000);
    send_item(MODE_UNUSED, 30'h0000_0000);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 14;
          recv_idle = 64;
        end
        1: begin
          send_idle = 64;
          recv_idle = 14;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == 0 && i == 20) hold_off = 1'b1;
        random_item();
      end
    end

    // exhaust the node pool with fresh keys, then keep working on a full pool
    n = 0;
    while (sb.full_seen < 3 && n < 250) begin
      send_item(MODE_INS, 30'($urandom()));
      n++;
    end
    repeat (30) random_item();

    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("binary_xor_trie_core_tb: done, clean");
    end else begin
      $display("binary_xor_trie_core_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bxt_pkg.sv
hdl/bxt_level.sv
hdl/binary_xor_trie_core.sv
hdl/bxt_checker.sv
tb/binary_xor_trie_core_tb.sv
